// ----- rtl/core/hmmd_pkg.sv -----
// ----------------------------------------------------------------------------
// hmmd_pkg
// Types and constants shared by the memory map decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hmmd_pkg;

   localparam int WORK_RAM_BYTES = 8192;
   localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
   localparam int HRAM_DEPTH     = 127;
   localparam int HRAM_AW        = 7;
   localparam int LOWIO_DEPTH    = 16;
   localparam int LOWIO_AW       = 4;
   localparam int IDX_W          = WRAM_AW;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      TGT_LOCAL    = 3'd0,
      TGT_CART     = 3'd1,
      TGT_VIDEO    = 3'd2,
      TGT_AUDIO    = 3'd3,
      TGT_UNUSABLE = 3'd4
   } target_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_WRAM  = 3'd1,
      KIND_HRAM  = 3'd2,
      KIND_LOWIO = 3'd3,
      KIND_DMA   = 3'd4,
      KIND_BOOT  = 3'd5,
      KIND_IE    = 3'd6
   } kind_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      target_type target;
      logic [7:0] rdata;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      target_type       target;
      kind_type         kind;
      logic [IDX_W-1:0] index;
      logic [7:0]       wdata;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/core/hmmd_front.sv -----
// ----------------------------------------------------------------------------
// hmmd_front
// Accepts bus accesses and classifies them against the memory map.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmd_front (
   input  wire              req_valid,
   output logic             req_ready,
   input  hmmd_pkg::req_type req_data,
   output logic             cmd_valid,
   input  wire              cmd_ready,
   output hmmd_pkg::cmd_type cmd_data
);

   localparam logic [15:0] CART_LO_END  = 16'h7fff;
   localparam logic [15:0] VRAM_END     = 16'h9fff;
   localparam logic [15:0] CART_HI_END  = 16'hbfff;
   localparam logic [15:0] ECHO_END     = 16'hfdff;
   localparam logic [15:0] OAM_END      = 16'hfe9f;
   localparam logic [15:0] HOLE_END     = 16'hfeff;
   localparam logic [15:0] LOWIO_END    = 16'hff0f;
   localparam logic [15:0] SOUND_END    = 16'hff26;
   localparam logic [15:0] SOUND_GAP    = 16'hff29;
   localparam logic [15:0] WAVE_END     = 16'hff3f;
   localparam logic [15:0] LCD_LO_END   = 16'hff45;
   localparam logic [15:0] DMA_ADDR     = 16'hff46;
   localparam logic [15:0] LCD_HI_END   = 16'hff4b;
   localparam logic [15:0] LCD_GAP_END  = 16'hff4f;
   localparam logic [15:0] BOOT_ADDR    = 16'hff50;
   localparam logic [15:0] IO_HOLE_END  = 16'hff7f;
   localparam logic [15:0] HRAM_END     = 16'hfffe;

   hmmd_pkg::target_type tgt;
   hmmd_pkg::kind_type   kind;
   logic [15:0]          a;

   assign a = req_data.addr;

   always_comb begin
      tgt  = hmmd_pkg::TGT_LOCAL;
      kind = hmmd_pkg::KIND_NONE;
      if (a <= CART_LO_END) begin
         tgt = hmmd_pkg::TGT_CART;
      end else if (a <= VRAM_END) begin
         tgt = hmmd_pkg::TGT_VIDEO;
      end else if (a <= CART_HI_END) begin
         tgt = hmmd_pkg::TGT_CART;
      end else if (a <= ECHO_END) begin
         kind = hmmd_pkg::KIND_WRAM;
      end else if (a <= OAM_END) begin
         tgt = hmmd_pkg::TGT_VIDEO;
      end else if (a <= HOLE_END) begin
         tgt = hmmd_pkg::TGT_UNUSABLE;
      end else if (a <= LOWIO_END) begin
         kind = hmmd_pkg::KIND_LOWIO;
      end else if (a <= SOUND_END) begin
         tgt = hmmd_pkg::TGT_AUDIO;
      end else if (a <= SOUND_GAP) begin
         tgt = hmmd_pkg::TGT_UNUSABLE;
      end else if (a <= WAVE_END) begin
         tgt = hmmd_pkg::TGT_AUDIO;
      end else if (a <= LCD_LO_END) begin
         tgt = hmmd_pkg::TGT_VIDEO;
      end else if (a == DMA_ADDR) begin
         kind = hmmd_pkg::KIND_DMA;
      end else if (a <= LCD_HI_END) begin
         tgt = hmmd_pkg::TGT_VIDEO;
      end else if (a <= LCD_GAP_END) begin
         tgt = hmmd_pkg::TGT_UNUSABLE;
      end else if (a == BOOT_ADDR) begin
         kind = hmmd_pkg::KIND_BOOT;
      end else if (a <= IO_HOLE_END) begin
         tgt = hmmd_pkg::TGT_UNUSABLE;
      end else if (a <= HRAM_END) begin
         kind = hmmd_pkg::KIND_HRAM;
      end else begin
         kind = hmmd_pkg::KIND_IE;
      end
   end

   assign cmd_valid      = req_valid;
   assign req_ready      = cmd_ready;
   assign cmd_data.op     = req_data.op;
   assign cmd_data.target = tgt;
   assign cmd_data.kind   = kind;
   // work RAM and its echo both map to the low address bits
   assign cmd_data.index  = a[hmmd_pkg::IDX_W-1:0];
   assign cmd_data.wdata  = req_data.wdata;

endmodule

`default_nettype wire

// ----- rtl/core/hmmd_queue.sv -----
// ----------------------------------------------------------------------------
// hmmd_queue
// Two-beat queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmd_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  hmmd_pkg::cmd_type in_data,
   output logic              out_valid,
   input  wire               out_ready,
   output hmmd_pkg::cmd_type out_data
);

   hmmd_pkg::cmd_type entry_ff [2];
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/hmmd_back.sv -----
// ----------------------------------------------------------------------------
// hmmd_back
// Executes decoded accesses against local storage and drives the results.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmd_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   output logic              cmd_ready,
   input  hmmd_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output hmmd_pkg::rsp_type rsp_data
);

   logic [7:0] wram_mem [hmmd_pkg::WORK_RAM_BYTES];
   logic [7:0] hram_mem [hmmd_pkg::HRAM_DEPTH];
   logic [7:0] lowio_ff [hmmd_pkg::LOWIO_DEPTH];
   logic [7:0] dma_ff;
   logic [7:0] boot_ff;
   logic [7:0] ie_ff;

   logic                    s1_valid_ff;
   hmmd_pkg::op_type        s1_op_ff;
   hmmd_pkg::target_type    s1_tgt_ff;
   hmmd_pkg::kind_type      s1_kind_ff;
   logic [7:0]              s1_reg_rd_ff;
   logic [7:0]              s1_reg_rd_in;
   logic [7:0]              wram_rd_ff;
   logic [7:0]              hram_rd_ff;

   logic                    rsp_valid_ff;
   hmmd_pkg::rsp_type       rsp_data_ff;
   hmmd_pkg::rsp_type       rsp_data_in;

   logic                    pop;
   logic                    rsp_load;
   logic                    is_write;
   logic [hmmd_pkg::WRAM_AW-1:0]  wram_idx;
   logic [hmmd_pkg::HRAM_AW-1:0]  hram_idx;
   logic [hmmd_pkg::LOWIO_AW-1:0] lowio_idx;

   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = !s1_valid_ff || rsp_load;
   assign pop       = cmd_valid && cmd_ready;
   assign is_write  = (cmd_data.op == hmmd_pkg::OP_WRITE);
   assign wram_idx  = cmd_data.index[hmmd_pkg::WRAM_AW-1:0];
   assign hram_idx  = cmd_data.index[hmmd_pkg::HRAM_AW-1:0];
   assign lowio_idx = cmd_data.index[hmmd_pkg::LOWIO_AW-1:0];

   always_ff @(posedge clock) begin
      if (pop) begin
         if (is_write && cmd_data.kind == hmmd_pkg::KIND_WRAM) begin
            wram_mem[wram_idx] <= cmd_data.wdata;
         end
         wram_rd_ff <= wram_mem[wram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (is_write && cmd_data.kind == hmmd_pkg::KIND_HRAM) begin
            hram_mem[hram_idx] <= cmd_data.wdata;
         end
         hram_rd_ff <= hram_mem[hram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hmmd_pkg::LOWIO_DEPTH; i++) begin
            lowio_ff[i] <= 8'd0;
         end
         dma_ff  <= 8'd0;
         boot_ff <= 8'd0;
         ie_ff   <= 8'd0;
      end else if (pop && is_write) begin
         case (cmd_data.kind)
            hmmd_pkg::KIND_LOWIO: lowio_ff[lowio_idx] <= cmd_data.wdata;
            hmmd_pkg::KIND_DMA:   dma_ff  <= cmd_data.wdata;
            hmmd_pkg::KIND_BOOT:  boot_ff <= cmd_data.wdata;
            hmmd_pkg::KIND_IE:    ie_ff   <= cmd_data.wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cmd_data.kind)
         hmmd_pkg::KIND_LOWIO: s1_reg_rd_in = lowio_ff[lowio_idx];
         hmmd_pkg::KIND_DMA:   s1_reg_rd_in = dma_ff;
         hmmd_pkg::KIND_BOOT:  s1_reg_rd_in = boot_ff;
         hmmd_pkg::KIND_IE:    s1_reg_rd_in = ie_ff;
         default:              s1_reg_rd_in = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pop) begin
         s1_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff     <= cmd_data.op;
         s1_tgt_ff    <= cmd_data.target;
         s1_kind_ff   <= cmd_data.kind;
         s1_reg_rd_ff <= s1_reg_rd_in;
      end
   end

   always_comb begin
      rsp_data_in.target = s1_tgt_ff;
      case (s1_kind_ff)
         hmmd_pkg::KIND_WRAM: rsp_data_in.rdata = wram_rd_ff;
         hmmd_pkg::KIND_HRAM: rsp_data_in.rdata = hram_rd_ff;
         hmmd_pkg::KIND_NONE: begin
            rsp_data_in.rdata = (s1_tgt_ff == hmmd_pkg::TGT_UNUSABLE) ? 8'hff : 8'h00;
         end
         default:             rsp_data_in.rdata = s1_reg_rd_ff;
      endcase
      if (s1_op_ff == hmmd_pkg::OP_WRITE) begin
         rsp_data_in.rdata = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/handheld_memory_map_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_unit
// Decodes 8-bit bus accesses against the handheld console memory map.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req_data) carries one access per beat:
// op, 16-bit addr and wdata. Response channel (rsp_valid/rsp_ready/rsp_data)
// returns one beat per access, in order: the target code and the read byte.
// Local targets (work RAM with its echo, high RAM, low I/O bytes, DMA, boot
// and interrupt-enable bytes) are stored here; external targets read 0 and
// unusable addresses read 0xFF. Writes always return rdata 0.
// An accepted request is decoded into a two-beat queue, then passes through
// the registered RAM read before the response register. Throughput: one
// access per cycle while the receiver does not stall, set by the single-port
// work RAM and high RAM, each taking one read or write per cycle.
// Reset clears the queue, the pipeline and the low I/O, DMA, boot and
// interrupt-enable bytes to zero; RAM contents stay unknown until written.
// When the receiver stalls, the response register holds, the execute stage
// and queue fill, and req_ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_memory_map_decoder_unit (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  hmmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output hmmd_pkg::rsp_type rsp_data
);

   logic              fq_valid;
   logic              fq_ready;
   hmmd_pkg::cmd_type fq_data;
   logic              qb_valid;
   logic              qb_ready;
   hmmd_pkg::cmd_type qb_data;

   hmmd_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd_data  (fq_data)
   );

   hmmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   hmmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !qb_valid)
      else $error("response or queue valid after reset");

   a_external_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.target == hmmd_pkg::TGT_CART ||
                    rsp_data.target == hmmd_pkg::TGT_VIDEO ||
                    rsp_data.target == hmmd_pkg::TGT_AUDIO)
      |-> rsp_data.rdata == 8'h00)
      else $error("external target returned nonzero data");

   a_unusable_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target == hmmd_pkg::TGT_UNUSABLE
      |-> rsp_data.rdata == 8'hff || rsp_data.rdata == 8'h00)
      else $error("unusable target returned stored data");

   a_queue_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> qb_valid)
      else $error("request stalled with empty queue");

endmodule

`default_nettype wire

// ----- dv/handheld_memory_map_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_unit_tb
// Self-checking bench for the memory map decoder. A directed pass walks
// many region boundaries and each kind of local storage. A random pass
// follows: work RAM and high RAM traffic reading only stored bytes, other
// local bytes, and boundary and fully random addresses. Both channels stall
// at random, except for one long stretch with none. Every response beat is
// checked in order against a model of the map and its local storage.
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_unit_tb;

   localparam int HALF_PERIOD  = 5;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_BEATS = 420;
   localparam int MAX_REPORTS  = 10;
   localparam logic [15:0] MAP_LIMITS [19] = '{
      16'h7fff, 16'h9fff, 16'hbfff, 16'hdfff, 16'hfdff, 16'hfe9f, 16'hfeff,
      16'hff0f, 16'hff26, 16'hff29, 16'hff3f, 16'hff45, 16'hff46, 16'hff4b,
      16'hff4f, 16'hff50, 16'hff7f, 16'hfffe, 16'hffff};

   class access_scoreboard;
      logic [7:0] wram [hmmd_pkg::WORK_RAM_BYTES];
      logic [7:0] hram [hmmd_pkg::HRAM_DEPTH];
      logic [7:0] lowio [hmmd_pkg::LOWIO_DEPTH];
      logic [7:0] dma_reg;
      logic [7:0] boot_reg;
      logic [7:0] ie_reg;
      bit         wram_stored [hmmd_pkg::WORK_RAM_BYTES];
      bit         hram_stored [hmmd_pkg::HRAM_DEPTH];
      int         wram_written [$];
      int         hram_written [$];
      hmmd_pkg::rsp_type pending_rsp [$];
      int         error_count;

      function new();
         foreach (lowio[i]) lowio[i] = 8'h00;
         dma_reg     = 8'h00;
         boot_reg    = 8'h00;
         ie_reg      = 8'h00;
         error_count = 0;
      endfunction

      function hmmd_pkg::target_type decode_addr(input logic [15:0] a,
                                                 output hmmd_pkg::kind_type kind,
                                                 output int idx);
         kind = hmmd_pkg::KIND_NONE;
         idx  = 0;
         if (a <= 16'h7fff) return hmmd_pkg::TGT_CART;
         if (a <= 16'h9fff) return hmmd_pkg::TGT_VIDEO;
         if (a <= 16'hbfff) return hmmd_pkg::TGT_CART;
         if (a <= 16'hdfff) begin
            kind = hmmd_pkg::KIND_WRAM;
            idx  = int'(a - 16'hc000);
            return hmmd_pkg::TGT_LOCAL;
         end
         if (a <= 16'hfdff) begin
            kind = hmmd_pkg::KIND_WRAM;
            idx  = int'(a - 16'he000);
            return hmmd_pkg::TGT_LOCAL;
         end
         if (a <= 16'hfe9f) return hmmd_pkg::TGT_VIDEO;
         if (a <= 16'hfeff) return hmmd_pkg::TGT_UNUSABLE;
         if (a <= 16'hff0f) begin
            kind = hmmd_pkg::KIND_LOWIO;
            idx  = int'(a[3:0]);
            return hmmd_pkg::TGT_LOCAL;
         end
         if (a <= 16'hff26) return hmmd_pkg::TGT_AUDIO;
         if (a <= 16'hff29) return hmmd_pkg::TGT_UNUSABLE;
         if (a <= 16'hff3f) return hmmd_pkg::TGT_AUDIO;
         if (a <= 16'hff45) return hmmd_pkg::TGT_VIDEO;
         if (a == 16'hff46) begin
            kind = hmmd_pkg::KIND_DMA;
            return hmmd_pkg::TGT_LOCAL;
         end
         if (a <= 16'hff4b) return hmmd_pkg::TGT_VIDEO;
         if (a <= 16'hff4f) return hmmd_pkg::TGT_UNUSABLE;
         if (a == 16'hff50) begin
            kind = hmmd_pkg::KIND_BOOT;
            return hmmd_pkg::TGT_LOCAL;
         end
         if (a <= 16'hff7f) return hmmd_pkg::TGT_UNUSABLE;
         if (a <= 16'hfffe) begin
            kind = hmmd_pkg::KIND_HRAM;
            idx  = int'(a - 16'hff80);
            return hmmd_pkg::TGT_LOCAL;
         end
         kind = hmmd_pkg::KIND_IE;
         return hmmd_pkg::TGT_LOCAL;
      endfunction

      function void report_error(string msg);
         error_count++;
         if (error_count <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
      endfunction

      function void note_request(hmmd_pkg::req_type r);
         hmmd_pkg::kind_type kind;
         int                 idx;
         hmmd_pkg::rsp_type  e;
         e.target = decode_addr(r.addr, kind, idx);
         e.rdata  = 8'h00;
         if (r.op == hmmd_pkg::OP_WRITE) begin
            case (kind)
               hmmd_pkg::KIND_WRAM: begin
                  wram[idx] = r.wdata;
                  if (!wram_stored[idx]) begin
                     wram_stored[idx] = 1'b1;
                     wram_written.push_back(idx);
                  end
               end
               hmmd_pkg::KIND_HRAM: begin
                  hram[idx] = r.wdata;
                  if (!hram_stored[idx]) begin
                     hram_stored[idx] = 1'b1;
                     hram_written.push_back(idx);
                  end
               end
               hmmd_pkg::KIND_LOWIO: lowio[idx] = r.wdata;
               hmmd_pkg::KIND_DMA:   dma_reg    = r.wdata;
               hmmd_pkg::KIND_BOOT:  boot_reg   = r.wdata;
               hmmd_pkg::KIND_IE:    ie_reg     = r.wdata;
               default:    ;
            endcase
         end else begin
            case (kind)
               hmmd_pkg::KIND_WRAM:  e.rdata = wram[idx];
               hmmd_pkg::KIND_HRAM:  e.rdata = hram[idx];
               hmmd_pkg::KIND_LOWIO: e.rdata = lowio[idx];
               hmmd_pkg::KIND_DMA:   e.rdata = dma_reg;
               hmmd_pkg::KIND_BOOT:  e.rdata = boot_reg;
               hmmd_pkg::KIND_IE:    e.rdata = ie_reg;
               default: if (e.target == hmmd_pkg::TGT_UNUSABLE) e.rdata = 8'hff;
            endcase
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_response(hmmd_pkg::rsp_type r);
         hmmd_pkg::rsp_type e;
         if (pending_rsp.size() == 0) begin
            report_error($sformatf("response beat with none pending: target %0d rdata %02h",
                                   r.target, r.rdata));
            return;
         end
         e = pending_rsp.pop_front();
         if (r.target !== e.target || r.rdata !== e.rdata)
            report_error($sformatf("target exp %0d got %0d, rdata exp %02h got %02h",
                                   e.target, r.target, e.rdata, r.rdata));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   hmmd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   hmmd_pkg::rsp_type rsp_data;

   access_scoreboard sb;
   bit               calm;
   int               idle_cycles = 0;

   handheld_memory_map_decoder_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 17);
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_access(hmmd_pkg::op_type op, logic [15:0] a, logic [7:0] d);
      hmmd_pkg::req_type r;
      r.op    = op;
      r.addr  = a;
      r.wdata = d;
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic hmmd_pkg::req_type next_random_access();
      hmmd_pkg::req_type  r;
      int                 pick;
      int                 idx;
      hmmd_pkg::kind_type kind;
      pick    = $urandom_range(0, 99);
      r.op    = hmmd_pkg::op_type'($urandom_range(0, 1));
      r.wdata = 8'($urandom);
      r.addr  = 16'($urandom);
      if (pick < 30) begin
         if (r.op == hmmd_pkg::OP_READ && sb.wram_written.size() != 0) begin
            idx = sb.wram_written[$urandom_range(0, sb.wram_written.size() - 1)];
         end else begin
            r.op = hmmd_pkg::OP_WRITE;
            idx  = $urandom_range(0, hmmd_pkg::WORK_RAM_BYTES - 1);
         end
         if (idx < 16'h1e00 && $urandom_range(0, 2) == 0) r.addr = 16'(16'he000 + idx);
         else r.addr = 16'(16'hc000 + idx);
      end else if (pick < 45) begin
         if (r.op == hmmd_pkg::OP_READ && sb.hram_written.size() != 0) begin
            idx = sb.hram_written[$urandom_range(0, sb.hram_written.size() - 1)];
         end else begin
            r.op = hmmd_pkg::OP_WRITE;
            idx  = $urandom_range(0, hmmd_pkg::HRAM_DEPTH - 1);
         end
         r.addr = 16'(16'hff80 + idx);
      end else if (pick < 55) begin
         case ($urandom_range(0, 3))
            0:       r.addr = 16'(16'hff00 + $urandom_range(0, hmmd_pkg::LOWIO_DEPTH - 1));
            1:       r.addr = 16'hff46;
            2:       r.addr = 16'hff50;
            default: r.addr = 16'hffff;
         endcase
      end else begin
         if (pick < 72) r.addr = 16'(MAP_LIMITS[$urandom_range(0, 18)] + $urandom_range(0, 1));
         void'(sb.decode_addr(r.addr, kind, idx));
         if (r.op == hmmd_pkg::OP_READ &&
             ((kind == hmmd_pkg::KIND_WRAM && !sb.wram_stored[idx]) ||
              (kind == hmmd_pkg::KIND_HRAM && !sb.hram_stored[idx])))
            r.op = hmmd_pkg::OP_WRITE;
      end
      return r;
   endfunction

   initial begin
      hmmd_pkg::req_type r;
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      calm      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_access(hmmd_pkg::OP_READ,  16'h0000, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'h7fff, 8'ha5);
      send_access(hmmd_pkg::OP_READ,  16'h8000, 8'hff);
      send_access(hmmd_pkg::OP_WRITE, 16'h9fff, 8'h5a);
      send_access(hmmd_pkg::OP_READ,  16'ha000, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hc000, 8'hff);
      send_access(hmmd_pkg::OP_WRITE, 16'hfdff, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'he000, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hddff, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hfe9f, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hfea0, 8'h77);
      send_access(hmmd_pkg::OP_READ,  16'hfeff, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hff00, 8'h3c);
      send_access(hmmd_pkg::OP_READ,  16'hff0f, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff00, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff26, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff27, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff30, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff45, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff46, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hff46, 8'h81);
      send_access(hmmd_pkg::OP_READ,  16'hff46, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff4c, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hff50, 8'h01);
      send_access(hmmd_pkg::OP_READ,  16'hff50, 8'h00);
      send_access(hmmd_pkg::OP_READ,  16'hff7f, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hfffe, 8'hc3);
      send_access(hmmd_pkg::OP_READ,  16'hfffe, 8'h00);
      send_access(hmmd_pkg::OP_WRITE, 16'hffff, 8'h1f);
      send_access(hmmd_pkg::OP_READ,  16'hffff, 8'h00);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n >= 150 && n < 250);
         r    = next_random_access();
         send_access(r.op, r.addr, r.wdata);
      end
      calm      = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- handheld_memory_map_decoder_unit.f -----
rtl/core/hmmd_pkg.sv
rtl/core/hmmd_front.sv
rtl/core/hmmd_queue.sv
rtl/core/hmmd_back.sv
rtl/core/handheld_memory_map_decoder_unit.sv
dv/handheld_memory_map_decoder_unit_tb.sv
